>>> design/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg: shared types and constants of the bitmap block allocator
// Sizes of the request and response fields, operation codes and the
// controller states.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int BLOCKS = 64;
    localparam int IDX_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int OP_W   = 3;
    localparam int CNT_W  = 7;
    localparam int BLK_W  = 6;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC_CONTIG  = 3'd0,
        OP_ALLOC_SCATTER = 3'd1,
        OP_ALLOC_ONE     = 3'd2,
        OP_FREE          = 3'd3,
        OP_QUERY         = 3'd4,
        OP_COUNT         = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CSCAN,
        ST_CEMIT,
        ST_SCAT,
        ST_FAIL
    } state_t;

endpackage

>>> design/bba_req_if.sv
// ----------------------------------------------------------------------------
// bba_req_if: request channel of the bitmap block allocator
// Valid/ready handshake carrying one allocator request.
// ----------------------------------------------------------------------------
interface bba_req_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [CNT_W-1:0] request_count;
    logic [BLK_W-1:0] target_block;

    modport source (output valid, output operation, output request_count,
                    output target_block, input ready);
    modport sink   (input valid, input operation, input request_count,
                    input target_block, output ready);
endinterface

>>> design/bba_rsp_if.sv
// ----------------------------------------------------------------------------
// bba_rsp_if: response channel of the bitmap block allocator
// Valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic [BLK_W-1:0] granted_block;
    logic             block_valid;
    logic             ok;
    logic             is_free;
    logic [CNT_W-1:0] free_total;
    logic             last;

    modport source (output valid, output granted_block, output block_valid,
                    output ok, output is_free, output free_total, output last,
                    input ready);
    modport sink   (input valid, input granted_block, input block_valid,
                    input ok, input is_free, input free_total, input last,
                    output ready);
endinterface

>>> design/bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit allocator over a free bitmap
// Free bitmap kept in a rotating shift register, scanned one block per cycle.
// ----------------------------------------------------------------------------
// One request is taken at a time. Free, query, count and requests that fail
// on the free count answer in the cycle after they are taken. Scattered and
// single allocations rotate the bitmap once through its one-bit scan position,
// emitting a grant as each picked block passes. A contiguous allocation
// rotates the bitmap once to find and clear the lowest long enough run, then
// emits its n grants one per cycle while the response channel takes them.
// A full response register sits between the core and the response channel,
// and a stalled response channel holds the scan.
module bitmap_block_allocator
(
    input  logic clk,
    input  logic rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);
    import bba_pkg::*;

    state_t            state_reg, state_next;
    logic [BLOCKS-1:0] map_reg, map_next;
    logic [CNT_W-1:0]  free_reg, free_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  left_reg, left_next;
    logic [IDX_W-1:0]  blk_reg, blk_next;
    logic              found_reg, found_next;

    logic              ov_reg, ov_next;
    logic [BLK_W-1:0]  o_blk_reg, o_blk_next;
    logic              o_bv_reg, o_bv_next;
    logic              o_ok_reg, o_ok_next;
    logic              o_isf_reg, o_isf_next;
    logic [CNT_W-1:0]  o_free_reg, o_free_next;
    logic              o_last_reg, o_last_next;

    logic              out_free;
    logic              bit_cur;
    logic              want;
    logic              scan_end;
    logic [CNT_W-1:0]  run_inc;
    logic [CNT_W-1:0]  start_w;
    logic [BLOCKS-1:0] top_mask;
    logic [CNT_W-1:0]  tgt_w;
    logic              tgt_ok;

    assign out_free = !ov_reg || rsp.ready;
    assign bit_cur  = map_reg[0];
    assign scan_end = (idx_reg == IDX_W'(BLOCKS - 1));
    assign run_inc  = run_reg + CNT_W'(1);
    assign start_w  = CNT_W'(idx_reg) + CNT_W'(1) - cnt_reg;
    assign want     = bit_cur && (left_reg != '0);
    assign tgt_w    = CNT_W'(req.target_block);
    assign tgt_ok   = (tgt_w < CNT_W'(BLOCKS));

    // After the shift, the run that just completed sits in the top cnt bits.
    always_comb
    begin
        for (int b = 0; b < BLOCKS; b++)
        begin
            top_mask[b] = (CNT_W'(BLOCKS - b) <= cnt_reg);
        end
    end

    assign req.ready         = (state_reg == ST_IDLE) && out_free;
    assign rsp.valid         = ov_reg;
    assign rsp.granted_block = o_blk_reg;
    assign rsp.block_valid   = o_bv_reg;
    assign rsp.ok            = o_ok_reg;
    assign rsp.is_free       = o_isf_reg;
    assign rsp.free_total    = o_free_reg;
    assign rsp.last          = o_last_reg;

    always_comb
    begin
        state_next  = state_reg;
        map_next    = map_reg;
        free_next   = free_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        cnt_next    = cnt_reg;
        left_next   = left_reg;
        blk_next    = blk_reg;
        found_next  = found_reg;
        ov_next     = ov_reg && !rsp.ready;
        o_blk_next  = o_blk_reg;
        o_bv_next   = o_bv_reg;
        o_ok_next   = o_ok_reg;
        o_isf_next  = o_isf_reg;
        o_free_next = o_free_reg;
        o_last_next = o_last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid && out_free)
                begin
                    // default: single non-grant item, ok cleared
                    ov_next     = 1'b1;
                    o_blk_next  = '0;
                    o_bv_next   = 1'b0;
                    o_ok_next   = 1'b0;
                    o_isf_next  = 1'b0;
                    o_last_next = 1'b1;
                    idx_next    = '0;
                    run_next    = '0;
                    found_next  = 1'b0;
                    cnt_next    = req.request_count;
                    unique case (req.operation)
                        OP_ALLOC_CONTIG:
                        begin
                            if (req.request_count != '0 && req.request_count <= free_reg)
                            begin
                                ov_next    = 1'b0;
                                state_next = ST_CSCAN;
                            end
                        end
                        OP_ALLOC_SCATTER:
                        begin
                            if (req.request_count <= free_reg)
                            begin
                                if (req.request_count == '0)
                                begin
                                    o_ok_next = 1'b1;
                                end
                                else
                                begin
                                    ov_next    = 1'b0;
                                    free_next  = free_reg - req.request_count;
                                    left_next  = req.request_count;
                                    state_next = ST_SCAT;
                                end
                            end
                        end
                        OP_ALLOC_ONE:
                        begin
                            if (free_reg != '0)
                            begin
                                ov_next    = 1'b0;
                                free_next  = free_reg - CNT_W'(1);
                                left_next  = CNT_W'(1);
                                state_next = ST_SCAT;
                            end
                        end
                        OP_FREE:
                        begin
                            if (tgt_ok)
                            begin
                                o_ok_next = 1'b1;
                                if (!map_reg[req.target_block[IDX_W-1:0]])
                                begin
                                    map_next[req.target_block[IDX_W-1:0]] = 1'b1;
                                    free_next = free_reg + CNT_W'(1);
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            o_ok_next  = 1'b1;
                            o_isf_next = tgt_ok && map_reg[req.target_block[IDX_W-1:0]];
                        end
                        OP_COUNT:
                        begin
                            o_ok_next = 1'b1;
                        end
                        default:
                        begin
                            o_ok_next = 1'b0;
                        end
                    endcase
                    o_free_next = free_next;
                end
            end

            ST_CSCAN:
            begin
                // rotate every cycle; first fit completes at most once a pass
                map_next = {bit_cur, map_reg[BLOCKS-1:1]};
                idx_next = idx_reg + IDX_W'(1);
                if (!found_reg)
                begin
                    if (bit_cur)
                    begin
                        run_next = run_inc;
                        if (run_inc == cnt_reg)
                        begin
                            found_next = 1'b1;
                            map_next   = {bit_cur, map_reg[BLOCKS-1:1]} & ~top_mask;
                            free_next  = free_reg - cnt_reg;
                            blk_next   = start_w[IDX_W-1:0];
                        end
                    end
                    else
                    begin
                        run_next = '0;
                    end
                end
                if (scan_end)
                begin
                    left_next  = cnt_reg;
                    state_next = (found_next) ? ST_CEMIT : ST_FAIL;
                end
            end

            ST_CEMIT:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_blk_next  = BLK_W'(blk_reg);
                    o_bv_next   = 1'b1;
                    o_ok_next   = 1'b1;
                    o_isf_next  = 1'b0;
                    o_free_next = free_reg;
                    o_last_next = (left_reg == CNT_W'(1));
                    blk_next    = blk_reg + IDX_W'(1);
                    left_next   = left_reg - CNT_W'(1);
                    if (left_reg == CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_SCAT:
            begin
                // hold the rotation while a grant waits for the response slot
                if (!want || out_free)
                begin
                    map_next = {bit_cur && !want, map_reg[BLOCKS-1:1]};
                    idx_next = idx_reg + IDX_W'(1);
                    if (want)
                    begin
                        ov_next     = 1'b1;
                        o_blk_next  = BLK_W'(idx_reg);
                        o_bv_next   = 1'b1;
                        o_ok_next   = 1'b1;
                        o_isf_next  = 1'b0;
                        o_free_next = free_reg;
                        o_last_next = (left_reg == CNT_W'(1));
                        left_next   = left_reg - CNT_W'(1);
                    end
                    if (scan_end)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_FAIL:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    o_blk_next  = '0;
                    o_bv_next   = 1'b0;
                    o_ok_next   = 1'b0;
                    o_isf_next  = 1'b0;
                    o_free_next = free_reg;
                    o_last_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            map_reg   <= '1;
            free_reg  <= CNT_W'(BLOCKS);
            idx_reg   <= '0;
            run_reg   <= '0;
            left_reg  <= '0;
            found_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            map_reg   <= map_next;
            free_reg  <= free_next;
            idx_reg   <= idx_next;
            run_reg   <= run_next;
            left_reg  <= left_next;
            found_reg <= found_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        blk_reg    <= blk_next;
        o_blk_reg  <= o_blk_next;
        o_bv_reg   <= o_bv_next;
        o_ok_reg   <= o_ok_next;
        o_isf_reg  <= o_isf_next;
        o_free_reg <= o_free_next;
        o_last_reg <= o_last_next;
    end

    a_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(BLOCKS))
        else $error("free count above block total");

    a_count_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(map_reg) == free_reg))
        else $error("free count disagrees with bitmap");

    a_grant_is_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_bv_reg) |-> o_ok_reg)
        else $error("granted block without ok");

    a_scan_done_granted: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAT && scan_end && (!want || out_free))
        |-> (left_reg == '0 || (left_reg == CNT_W'(1) && want)))
        else $error("scattered scan ended with grants missing");

endmodule
